// ----- hdl/ordered_list_insert_delete_core_assert.svh -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core_assert.svh
// Assertion macros used by the checker of the ordered list block.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OLI_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("oli assertion failed");

// Next-cycle implication, disabled during reset.
`define OLI_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("oli assertion failed");

`endif

// ----- hdl/oli_pkg.sv -----
// ----------------------------------------------------------------------------
// oli_pkg
// Types and fixed field widths of the ordered list insert/delete block.
// ----------------------------------------------------------------------------
package oli_pkg;

    // Fixed widths of the transfer fields
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int HELD_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_INS_BEFORE = 3'd1,
        OP_INS_AFTER  = 3'd2,
        OP_DEL_AT     = 3'd3,
        OP_DEL_VALUE  = 3'd4,
        OP_GET        = 3'd5,
        OP_SET        = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t kind;
        logic     scan_en;
    } cell_ctl_t;

endpackage

// ----- hdl/oli_cell.sv -----
// ----------------------------------------------------------------------------
// oli_cell
// One slot of the ordered list: holds a word, shifts it to or from its
// neighbors on a broadcast insert or remove, and reports probe hits.
// ----------------------------------------------------------------------------
module oli_cell
    import oli_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int IDX_W      = 7,
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [IDX_W-1:0]      where_idx,
    input  logic [IDX_W-1:0]      probe_idx,
    input  logic [WORD_WIDTH-1:0] new_word,
    input  logic [WORD_WIDTH-1:0] lower_word,
    input  logic [WORD_WIDTH-1:0] upper_word,
    output logic [WORD_WIDTH-1:0] entry,
    output logic                  hit,
    output logic [WORD_WIDTH-1:0] probe_word
);

    localparam logic [IDX_W-1:0] SELF = IDX_W'(INDEX);

    logic [WORD_WIDTH-1:0] entry_reg;
    logic [WORD_WIDTH-1:0] entry_next;
    logic                  probe_sel;

    // Pick the next word from the broadcast operation
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.kind)
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
            CELL_INSERT:
            begin
                if (SELF == where_idx)
                begin
                    entry_next = new_word;
                end
                else if (SELF > where_idx)
                begin
                    entry_next = lower_word;
                end
            end
            CELL_REMOVE:
            begin
                if (SELF >= where_idx)
                begin
                    entry_next = upper_word;
                end
            end
            CELL_WRITE:
            begin
                if (SELF == where_idx)
                begin
                    entry_next = new_word;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the word
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Report the word and a key match when probed
    assign probe_sel  = (SELF == probe_idx);
    assign hit        = ctl.scan_en && probe_sel && (entry_reg == new_word);
    assign probe_word = probe_sel ? entry_reg : '0;
    assign entry      = entry_reg;

endmodule

// ----- hdl/ordered_list_insert_delete_core.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// Ordered list of up to CAPACITY words in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command: op, position and
// entry_value. Output channel (out_valid / out_stall) returns one result per
// command: status, placed_at, read_word and entries_held.
// A command lands in a command register, executes there, and its result goes
// to the output register; a new command is taken while a result waits.
// Append, insert, delete at, get, set and clear execute without a scan: the
// result passes from the command register to the output register, and one
// command completes per cycle while the output is not stalled.
// Delete value walks the cells with a scan counter, one cell per cycle, from
// index zero up to the first match, or up to the count when no entry matches.
// Reset empties the list and both channel registers; the word store itself
// needs no clearing. While out_stall is high the result holds, the command
// register stays full and in_stall rises.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core
    import oli_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [POS_W-1:0]  position,
    input  logic [VAL_W-1:0]  entry_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STAT_W-1:0] status,
    output logic [POS_W-1:0]  placed_at,
    output logic [VAL_W-1:0]  read_word,
    output logic [HELD_W-1:0] entries_held
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;

    // Command register
    logic              cmd_valid_reg;
    op_t               cmd_op_reg;
    logic [POS_W-1:0]  cmd_pos_reg;
    logic [VAL_W-1:0]  cmd_value_reg;

    // Control state
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [CNT_W-1:0]  scan_reg;
    logic [CNT_W-1:0]  scan_next;

    // Output register
    logic              out_valid_reg;
    status_t           status_reg;
    logic [POS_W-1:0]  placed_reg;
    logic [VAL_W-1:0]  read_reg;
    logic [HELD_W-1:0] held_reg;

    // Decode and cell wiring
    logic                  in_xfer;
    logic                  out_free;
    logic                  finish;
    logic [IDX_W-1:0]      pos_x;
    logic [IDX_W-1:0]      fill_x;
    logic [IDX_W-1:0]      scan_x;
    logic                  is_full;
    logic                  in_range;
    logic                  scan_end;
    logic                  hit_any;
    cell_ctl_t             ctl;
    logic [IDX_W-1:0]      where_idx;
    logic [IDX_W-1:0]      probe_idx;
    logic [WORD_WIDTH-1:0] key_word;
    logic [WORD_WIDTH-1:0] probe_or;
    status_t               res_status;
    logic [IDX_W-1:0]      res_placed;
    logic [VAL_W-1:0]      res_word;

    logic [WORD_WIDTH-1:0] entry_w [CAPACITY];
    logic [WORD_WIDTH-1:0] probe_w [CAPACITY];
    logic [CAPACITY-1:0]   hit_vec;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = cmd_valid_reg && !finish;

    assign pos_x    = IDX_W'(cmd_pos_reg);
    assign fill_x   = IDX_W'(fill_reg);
    assign scan_x   = IDX_W'(scan_reg);
    assign is_full  = (fill_x >= IDX_W'(CAPACITY));
    assign in_range = (pos_x < fill_x);
    assign scan_end = (scan_x >= fill_x);
    assign key_word = WORD_WIDTH'(cmd_value_reg);
    assign hit_any  = |hit_vec;

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] lower_w;
        logic [WORD_WIDTH-1:0] upper_w;

        if (g == 0)
        begin : g_bottom
            assign lower_w = '0;
        end
        else
        begin : g_lower
            assign lower_w = entry_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_top
            assign upper_w = entry_w[g];
        end
        else
        begin : g_upper
            assign upper_w = entry_w[g+1];
        end

        oli_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .where_idx  (where_idx),
            .probe_idx  (probe_idx),
            .new_word   (key_word),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .entry      (entry_w[g]),
            .hit        (hit_vec[g]),
            .probe_word (probe_w[g])
        );
    end

    // Merge the probed word (only one cell drives a nonzero word)
    always_comb
    begin
        probe_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            probe_or = probe_or | probe_w[i];
        end
    end

    // Next state and scan counter
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid_reg && (cmd_op_reg == OP_DEL_VALUE))
                begin
                    state_next = S_SCAN;
                    scan_next  = '0;
                end
            end
            S_SCAN:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
                else if (!scan_end && !hit_any)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Cell command, completion and result
    always_comb
    begin
        ctl.kind    = CELL_HOLD;
        ctl.scan_en = (state_reg == S_SCAN);
        where_idx   = '0;
        probe_idx   = (state_reg == S_SCAN) ? scan_x : pos_x;
        finish      = 1'b0;
        res_status  = STAT_OK;
        res_placed  = '0;
        res_word    = '0;
        fill_next   = fill_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid_reg && (cmd_op_reg != OP_DEL_VALUE) && out_free)
                begin
                    finish = 1'b1;
                    unique case (cmd_op_reg)
                        OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER:
                        begin
                            if (is_full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                priority if ((cmd_op_reg == OP_APPEND) || !in_range)
                                begin
                                    where_idx = fill_x;
                                end
                                else if (cmd_op_reg == OP_INS_BEFORE)
                                begin
                                    where_idx = pos_x;
                                end
                                else
                                begin
                                    where_idx = pos_x + IDX_W'(1);
                                end
                                ctl.kind   = CELL_INSERT;
                                res_placed = where_idx;
                                fill_next  = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL_AT:
                        begin
                            if (in_range)
                            begin
                                ctl.kind   = CELL_REMOVE;
                                where_idx  = pos_x;
                                res_placed = pos_x;
                                fill_next  = fill_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status = STAT_RANGE;
                            end
                        end
                        OP_GET:
                        begin
                            if (in_range)
                            begin
                                res_word = VAL_W'(probe_or);
                            end
                            else
                            begin
                                res_status = STAT_RANGE;
                            end
                        end
                        OP_SET:
                        begin
                            priority if (in_range)
                            begin
                                ctl.kind   = CELL_WRITE;
                                where_idx  = pos_x;
                                res_placed = pos_x;
                            end
                            else if (is_full)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ctl.kind   = CELL_INSERT;
                                where_idx  = fill_x;
                                res_placed = fill_x;
                                fill_next  = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        OP_DEL_VALUE:
                        begin
                            finish = 1'b0;
                        end
                        default:
                        begin
                            finish = 1'b0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    if (out_free)
                    begin
                        finish     = 1'b1;
                        res_status = STAT_MISSING;
                    end
                end
                else if (hit_any)
                begin
                    if (out_free)
                    begin
                        finish     = 1'b1;
                        ctl.kind   = CELL_REMOVE;
                        where_idx  = scan_x;
                        res_placed = scan_x;
                        fill_next  = fill_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            scan_reg  <= scan_next;
            if (in_xfer)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (finish)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the command and the result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_op_reg    <= op_t'(op);
            cmd_pos_reg   <= position;
            cmd_value_reg <= entry_value;
        end
        if (finish)
        begin
            status_reg <= res_status;
            placed_reg <= res_placed[POS_W-1:0];
            read_reg   <= res_word;
            held_reg   <= HELD_W'(fill_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign placed_at    = placed_reg;
    assign read_word    = read_reg;
    assign entries_held = held_reg;

endmodule

// ----- hdl/oli_checker.sv -----
// ----------------------------------------------------------------------------
// oli_checker
// Port-level checks of the ordered list block, bound to its top level.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_delete_core_assert.svh"

module oli_checker
    import oli_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [STAT_W-1:0] status,
    input logic [POS_W-1:0]  placed_at,
    input logic [VAL_W-1:0]  read_word,
    input logic [HELD_W-1:0] entries_held
);

    // A refused or missed operation places and reads nothing
    `OLI_ASSERT_IMPLY(a_refused_empty, clk, rst_n, out_valid && (status != STAT_OK), (placed_at == '0) && (read_word == '0))

    // Full is reported only with the list at capacity
    `OLI_ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (status == STAT_FULL), entries_held == HELD_W'(CAPACITY))

    // Only a get returns a word, and a get places nothing
    `OLI_ASSERT_IMPLY(a_read_only_get, clk, rst_n, out_valid && (read_word != '0), (status == STAT_OK) && (placed_at == '0))

    // Hold a stalled result
    `OLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(placed_at) && $stable(read_word) && $stable(entries_held))

endmodule

bind ordered_list_insert_delete_core oli_checker #(
    .CAPACITY (CAPACITY)
) u_oli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .placed_at    (placed_at),
    .read_word    (read_word),
    .entries_held (entries_held)
);

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list insert/delete core.
// A table of directed commands runs first: empty-list errors, inserts past
// the count, insert-after placement, first-match delete by value, set in
// place versus set as append, and clear. Random episodes follow. They fill
// the list to capacity, drain it back to empty, or mix every operation. A
// shadow list fills in results the table omits; all are compared in order.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the core backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import oli_pkg::*;

    localparam int LIST_CAP     = 64;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_WAIT  = 100;
    localparam int PRINT_CAP    = 40;
    localparam int LONG_HOLD    = 300;

    typedef enum {EP_FILL, EP_DRAIN, EP_MIX} episode_t;

    typedef struct packed {
        status_t           status;
        logic [POS_W-1:0]  placed;
        logic [VAL_W-1:0]  word;
        logic [HELD_W-1:0] held;
    } list_result_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic             typed;
        list_result_t     want;
    } list_cmd_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   op           = '0;
    logic [POS_W-1:0]  position     = '0;
    logic [VAL_W-1:0]  entry_value  = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  placed_at;
    logic [VAL_W-1:0]  read_word;
    logic [HELD_W-1:0] entries_held;

    // Shadow copy of the list
    logic [VAL_W-1:0]  list_words [LIST_CAP];
    int                list_len = 0;

    list_result_t      expected_results [$];
    int                mismatches   = 0;
    int                cycles       = 0;
    int                results_seen = 0;
    bit                tx_quiet     = 1'b0;

    ordered_list_insert_delete_core #(
        .CAPACITY   (LIST_CAP),
        .WORD_WIDTH (VAL_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .position     (position),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .placed_at    (placed_at),
        .read_word    (read_word),
        .entries_held (entries_held)
    );

    always #1 clk = ~clk;

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycles, msg);
    endtask

    // Open a slot at where, shifting the entries above it up
    function automatic void shift_in(int where, logic [VAL_W-1:0] v);
        for (int i = list_len; i > where; i--)
            list_words[i] = list_words[i - 1];
        list_words[where] = v;
        list_len++;
    endfunction

    // Close the slot at where, shifting the entries above it down
    function automatic void shift_out(int where);
        for (int i = where; i + 1 < list_len; i++)
            list_words[i] = list_words[i + 1];
        list_len--;
    endfunction

    // Apply one command to the shadow list and return its result
    function automatic list_result_t apply_list_op(op_t o, logic [POS_W-1:0] p,
                                                   logic [VAL_W-1:0] v);
        list_result_t r;
        int where;
        int hit;
        r = '0;
        r.status = STAT_OK;
        case (o)
            OP_APPEND, OP_INS_BEFORE, OP_INS_AFTER:
            begin
                if (list_len >= LIST_CAP)
                    r.status = STAT_FULL;
                else
                begin
                    if (o == OP_APPEND || p >= list_len)
                        where = list_len;
                    else if (o == OP_INS_BEFORE)
                        where = p;
                    else
                        where = p + 1;
                    shift_in(where, v);
                    r.placed = POS_W'(where);
                end
            end
            OP_DEL_AT:
            begin
                if (p >= list_len)
                    r.status = STAT_RANGE;
                else
                begin
                    shift_out(p);
                    r.placed = p;
                end
            end
            OP_DEL_VALUE:
            begin
                hit = -1;
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_words[i] == v)
                        hit = i;
                if (hit < 0)
                    r.status = STAT_MISSING;
                else
                begin
                    shift_out(hit);
                    r.placed = POS_W'(hit);
                end
            end
            OP_GET:
            begin
                if (p >= list_len)
                    r.status = STAT_RANGE;
                else
                    r.word = list_words[p];
            end
            OP_SET:
            begin
                if (p < list_len)
                begin
                    list_words[p] = v;
                    r.placed = p;
                end
                else if (list_len >= LIST_CAP)
                    r.status = STAT_FULL;
                else
                begin
                    r.placed = POS_W'(list_len);
                    shift_in(list_len, v);
                end
            end
            default:
                list_len = 0;
        endcase
        r.held = HELD_W'(list_len);
        return r;
    endfunction

    function automatic list_cmd_t cmd_row(op_t o, int p, logic [VAL_W-1:0] v,
                                          bit typed = 1'b0, status_t st = STAT_OK,
                                          int at = 0, logic [VAL_W-1:0] w = '0,
                                          int held = 0);
        list_cmd_t c;
        c = '0;
        c.op          = o;
        c.pos         = POS_W'(p);
        c.val         = v;
        c.typed       = typed;
        c.want.status = st;
        c.want.placed = POS_W'(at);
        c.want.word   = w;
        c.want.held   = HELD_W'(held);
        return c;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Draw a command shaped by the episode and the current list contents
    function automatic list_cmd_t pick_cmd(episode_t mode);
        list_cmd_t c;
        int r;
        c = '0;
        r = $urandom_range(0, 99);
        case (mode)
            EP_FILL:
                c.op = r < 35 ? OP_APPEND : r < 55 ? OP_INS_BEFORE :
                       r < 75 ? OP_INS_AFTER : r < 85 ? OP_SET :
                       r < 93 ? OP_GET : r < 97 ? OP_DEL_AT : OP_DEL_VALUE;
            EP_DRAIN:
                c.op = r < 40 ? OP_DEL_AT : r < 75 ? OP_DEL_VALUE :
                       r < 85 ? OP_GET : r < 90 ? OP_SET :
                       r < 95 ? OP_APPEND : OP_INS_BEFORE;
            default:
                c.op = r < 3 ? OP_CLEAR : op_t'($urandom_range(0, 6));
        endcase

        // Position: mostly inside the list, sometimes anywhere or at the edges
        r = $urandom_range(0, 99);
        if (r < 65 && list_len > 0)
            c.pos = POS_W'($urandom_range(0, list_len - 1));
        else if (r < 85)
            c.pos = POS_W'($urandom_range(0, 63));
        else if (r < 90)
            c.pos = POS_W'(list_len);
        else if (r < 95)
            c.pos = '0;
        else
            c.pos = '1;

        // Value: random words, all-zero/all-one, walking ones, small repeats
        r = $urandom_range(0, 99);
        if (r < 55)
            c.val = $urandom();
        else if (r < 70)
            c.val = r[0] ? '1 : '0;
        else if (r < 80)
            c.val = 32'h1 << $urandom_range(0, 31);
        else
            c.val = VAL_W'($urandom_range(0, 15));

        // Search for a word that is present most of the time
        if (c.op == OP_DEL_VALUE && list_len > 0 && $urandom_range(0, 99) < 70)
            c.val = list_words[$urandom_range(0, list_len - 1)];
        return c;
    endfunction

    // Offer one command, hold it until the transfer, then predict its result
    task automatic offer(list_cmd_t c);
        int gap;
        list_result_t want;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= c.op;
        position    <= c.pos;
        entry_value <= c.val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = apply_list_op(c.op, c.pos, c.val);
        expected_results.push_back(c.typed ? c.want : want);
        @(negedge clk);
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, status, want.status));
                if (placed_at !== want.placed)
                    report_mismatch($sformatf("result %0d placed_at %0d, want %0d",
                                              results_seen, placed_at, want.placed));
                if (read_word !== want.word)
                    report_mismatch($sformatf("result %0d read_word %h, want %h",
                                              results_seen, read_word, want.word));
                if (entries_held !== want.held)
                    report_mismatch($sformatf("result %0d entries_held %0d, want %0d",
                                              results_seen, entries_held, want.held));
            end
        end
    end

    // Result side: random stalls, quiet stretches, and one long hold-off
    initial
    begin : result_drain
        int len;
        bit held_long;
        held_long = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_long && results_seen >= 400)
            begin
                held_long = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if ($urandom_range(0, 19) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(30, 120)) @(negedge clk);
            end
            len = pick_gap(1'b0);
            if (len > 0)
            begin
                out_stall <= 1'b1;
                repeat (len) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // Stimulus: directed table, then random episodes
    initial
    begin : stimulus
        list_cmd_t directed_rows [24];
        int sent;
        int budget;
        int extra;
        int r;
        episode_t mode;

        directed_rows = '{
            // empty list: every read and delete is refused
            cmd_row(OP_GET,        0,  32'h0,         1, STAT_RANGE,   0, 0, 0),
            cmd_row(OP_DEL_AT,     0,  32'h0,         1, STAT_RANGE,   0, 0, 0),
            cmd_row(OP_DEL_VALUE,  0,  32'h0,         1, STAT_MISSING, 0, 0, 0),
            // insert past the count appends
            cmd_row(OP_INS_BEFORE, 63, 32'hFFFF_FFFF, 1, STAT_OK,      0, 0, 1),
            cmd_row(OP_APPEND,     0,  32'h0,         1, STAT_OK,      1, 0, 2),
            // insert after lands one above the position
            cmd_row(OP_INS_AFTER,  0,  32'hA5A5_A5A5, 1, STAT_OK,      1, 0, 3),
            cmd_row(OP_INS_BEFORE, 0,  32'h5A5A_5A5A, 1, STAT_OK,      0, 0, 4),
            cmd_row(OP_GET,        3,  32'hFFFF_FFFF),
            cmd_row(OP_GET,        63, 32'h0,         1, STAT_RANGE,   0, 0, 4),
            // set below the count overwrites, past it appends
            cmd_row(OP_SET,        1,  32'h1234_5678, 1, STAT_OK,      1, 0, 4),
            cmd_row(OP_SET,        40, 32'h8000_0001, 1, STAT_OK,      4, 0, 5),
            cmd_row(OP_INS_AFTER,  40, 32'h0000_0001, 1, STAT_OK,      5, 0, 6),
            cmd_row(OP_APPEND,     17, 32'h5A5A_5A5A),
            // delete by value takes the first match only
            cmd_row(OP_DEL_VALUE,  0,  32'h5A5A_5A5A, 1, STAT_OK,      0, 0, 6),
            cmd_row(OP_DEL_VALUE,  0,  32'hDEAD_BEEF, 1, STAT_MISSING, 0, 0, 6),
            cmd_row(OP_DEL_AT,     63, 32'h0,         1, STAT_RANGE,   0, 0, 6),
            cmd_row(OP_DEL_AT,     5,  32'h0),
            cmd_row(OP_GET,        0,  32'h0),
            cmd_row(OP_DEL_AT,     0,  32'hFFFF_FFFF),
            // clear, then clear again on the empty list
            cmd_row(OP_CLEAR,      0,  32'h0,         1, STAT_OK,      0, 0, 0),
            cmd_row(OP_GET,        0,  32'h0,         1, STAT_RANGE,   0, 0, 0),
            cmd_row(OP_CLEAR,      63, 32'hFFFF_FFFF, 1, STAT_OK,      0, 0, 0),
            cmd_row(OP_SET,        0,  32'h7FFF_FFFF, 1, STAT_OK,      0, 0, 1),
            cmd_row(OP_INS_AFTER,  0,  32'h8000_0000)
        };

        // Hold reset, then release it
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i]);

        // Random episodes: fill to full, drain to empty, or mix
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            mode = r < 4 ? EP_FILL : r < 7 ? EP_DRAIN : EP_MIX;
            tx_quiet = ($urandom_range(0, 4) == 0);
            budget = (mode == EP_MIX) ? $urandom_range(20, 80) : 200;
            extra = $urandom_range(3, 10);
            while (budget > 0 && extra > 0 && sent < RANDOM_ITEMS)
            begin
                offer(pick_cmd(mode));
                sent++;
                budget--;
                if ((mode == EP_FILL && list_len == LIST_CAP) ||
                    (mode == EP_DRAIN && list_len == 0))
                    extra--;
            end
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then let the core settle
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
